// ----- src/qts_pkg.sv -----
// qts_pkg: shared types and constants for the quintic trajectory sampler
// used by qts_ctrl, qts_datapath and quintic_trajectory_sampler; no dependencies
package qts_pkg;

   // number of polynomial coefficients c0..c5
   localparam int NUM_COEF = 6;
   // width of the result index field
   localparam int INDEX_WIDTH = 16;
   // width of the configuration register index
   localparam int CSR_INDEX_WIDTH = 3;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_C0      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_C1      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_C2      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_C3      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_C4      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEF_C5      = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIME_STEP    = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SAMPLE_COUNT = 3'd7;

   // horner schedule: rounds 0..4, coefficient c(4-round) added each round
   localparam logic [2:0] TOP_COEF   = 3'd4;
   localparam logic [2:0] LAST_ROUND = 3'd4;

   // evaluation lanes, one accumulator each
   typedef enum logic [1:0] {
      LANE_POS = 2'd0,
      LANE_VEL = 2'd1,
      LANE_ACC = 2'd2
   } lane_type;

   // small constant factors applied to a coefficient
   typedef enum logic [2:0] {
      SCALE_1  = 3'd0,
      SCALE_2  = 3'd1,
      SCALE_3  = 3'd2,
      SCALE_4  = 3'd3,
      SCALE_5  = 3'd4,
      SCALE_6  = 3'd5,
      SCALE_12 = 3'd6,
      SCALE_20 = 3'd7
   } scale_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       accept;    // input transfer this cycle
      logic       init;      // past-end test and accumulator load
      logic       issue;     // start one horner step
      lane_type   lane;
      logic [2:0] coef_sel;
      scale_type  scale;
      logic       out_load;  // load result register, advance time
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic past_end;
   } status_type;

endpackage

// ----- src/qts_ctrl.sv -----
// qts_ctrl: sequencer for the quintic trajectory sampler
// drives the horner schedule over the shared multiplier; uses qts_pkg
module qts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  qts_pkg::status_type  status,
   output qts_pkg::cmd_type     cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_INIT  = 5'b00010,
      S_RUN   = 5'b00100,
      S_DRAIN = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [2:0]         round_ff, round_in;
   qts_pkg::lane_type  lane_ff, lane_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;
   logic               lane_active;
   qts_pkg::scale_type scale_sel;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // lane lengths: position 5 steps, velocity 4, acceleration 3
   always_comb begin
      lane_active = 1'b0;
      scale_sel   = qts_pkg::SCALE_1;
      case (lane_ff)
         qts_pkg::LANE_POS: begin
            lane_active = 1'b1;
            scale_sel   = qts_pkg::SCALE_1;
         end
         qts_pkg::LANE_VEL: begin
            lane_active = (round_ff < 3'd4);
            case (round_ff)
               3'd0:    scale_sel = qts_pkg::SCALE_4;
               3'd1:    scale_sel = qts_pkg::SCALE_3;
               3'd2:    scale_sel = qts_pkg::SCALE_2;
               default: scale_sel = qts_pkg::SCALE_1;
            endcase
         end
         qts_pkg::LANE_ACC: begin
            lane_active = (round_ff < 3'd3);
            case (round_ff)
               3'd0:    scale_sel = qts_pkg::SCALE_12;
               3'd1:    scale_sel = qts_pkg::SCALE_6;
               default: scale_sel = qts_pkg::SCALE_2;
            endcase
         end
         default: begin
            lane_active = 1'b0;
            scale_sel   = qts_pkg::SCALE_1;
         end
      endcase
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      lane_in      = lane_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.lane     = lane_ff;
      cmd.coef_sel = qts_pkg::TOP_COEF - round_ff;
      cmd.scale    = scale_sel;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init = 1'b1;
            round_in = '0;
            lane_in  = qts_pkg::LANE_POS;
            state_in = status.past_end ? S_DONE : S_RUN;
         end
         S_RUN: begin
            cmd.issue = lane_active;
            if (round_ff == qts_pkg::LAST_ROUND && lane_ff == qts_pkg::LANE_POS) begin
               state_in = S_DRAIN;
            end
            case (lane_ff)
               qts_pkg::LANE_POS: lane_in = qts_pkg::LANE_VEL;
               qts_pkg::LANE_VEL: lane_in = qts_pkg::LANE_ACC;
               default: begin
                  lane_in  = qts_pkg::LANE_POS;
                  round_in = round_ff + 3'd1;
               end
            endcase
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         round_ff     <= '0;
         lane_ff      <= qts_pkg::LANE_POS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         lane_ff      <= lane_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/qts_datapath.sv -----
// qts_datapath: configuration registers, time and index state, shared
// multiplier with horner accumulators and the result register; uses qts_pkg
module qts_datapath #(
   parameter int COUNT_WIDTH = 16,
   parameter int COEF_WIDTH  = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [qts_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [((COEF_WIDTH > 32) ? COEF_WIDTH : 32)-1:0] csr_wdata,
   input  logic                                  restart,
   input  qts_pkg::cmd_type                      cmd,
   output qts_pkg::status_type                   status,
   output logic signed [31:0]                    position,
   output logic signed [31:0]                    velocity,
   output logic signed [31:0]                    acceleration,
   output logic [qts_pkg::INDEX_WIDTH-1:0]       index_out,
   output logic                                  final_sample,
   output logic                                  past_end
);

   localparam int SW  = (COEF_WIDTH + 5 > 33) ? COEF_WIDTH + 5 : 33;
   localparam int CW1 = COUNT_WIDTH + 1;
   localparam int IXW = qts_pkg::INDEX_WIDTH;

   logic signed [COEF_WIDTH-1:0] coef_ff [qts_pkg::NUM_COEF];
   logic [31:0]                  step_ff;
   logic [COUNT_WIDTH-1:0]       count_ff;
   logic [31:0]                  time_ff;
   logic [COUNT_WIDTH-1:0]       index_ff;
   logic                         pe_ff;
   logic signed [31:0]           acc_ff [3];
   logic signed [39:0]           prod_ff;
   logic signed [31:0]           k_ff;
   logic                         wb_valid_ff;
   qts_pkg::lane_type            wb_lane_ff;
   logic signed [31:0]           pos_ff, vel_ff, accel_ff;
   logic [IXW-1:0]               index_out_ff;
   logic                         final_ff, past_end_ff;

   logic signed [31:0]           acc_sel;
   logic signed [32:0]           time_s;
   logic signed [63:0]           full_prod;
   logic signed [40:0]           sum;
   logic signed [31:0]           sum_sat;
   logic [COUNT_WIDTH+IXW-1:0]   index_wide;
   logic                         is_final;

   // coefficient times a small constant, saturated to 32 bits
   function automatic logic signed [31:0] scale_sat(input logic signed [COEF_WIDTH-1:0] c,
                                                    input qts_pkg::scale_type s);
      logic signed [SW-1:0] x;
      logic signed [SW-1:0] y;
      x = SW'(c);
      case (s)
         qts_pkg::SCALE_1:  y = x;
         qts_pkg::SCALE_2:  y = x <<< 1;
         qts_pkg::SCALE_3:  y = (x <<< 1) + x;
         qts_pkg::SCALE_4:  y = x <<< 2;
         qts_pkg::SCALE_5:  y = (x <<< 2) + x;
         qts_pkg::SCALE_6:  y = (x <<< 2) + (x <<< 1);
         qts_pkg::SCALE_12: y = (x <<< 3) + (x <<< 2);
         qts_pkg::SCALE_20: y = (x <<< 4) + (x <<< 2);
         default:           y = x;
      endcase
      if (y[SW-1:31] == {(SW-31){y[31]}}) begin
         return y[31:0];
      end else if (y[SW-1]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7fff_ffff;
      end
   endfunction

   assign status.past_end = (index_ff >= count_ff);

   // multiply stage: accumulator times time, floor shift by 24
   assign acc_sel   = acc_ff[cmd.lane];
   assign time_s    = $signed({1'b0, time_ff});
   assign full_prod = 64'(acc_sel) * 64'(time_s);

   // add stage with saturation
   assign sum = 41'(prod_ff) + 41'(k_ff);
   always_comb begin
      if (sum[40:31] == {10{sum[31]}}) begin
         sum_sat = sum[31:0];
      end else if (sum[40]) begin
         sum_sat = 32'sh8000_0000;
      end else begin
         sum_sat = 32'sh7fff_ffff;
      end
   end

   assign index_wide = {{IXW{1'b0}}, index_ff};
   assign is_final   = (CW1'(index_ff) + CW1'(1)) == CW1'(count_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < qts_pkg::NUM_COEF; i++) begin
            coef_ff[i] <= '0;
         end
         step_ff  <= '0;
         count_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            qts_pkg::CSR_COEF_C0:      coef_ff[0] <= csr_wdata[COEF_WIDTH-1:0];
            qts_pkg::CSR_COEF_C1:      coef_ff[1] <= csr_wdata[COEF_WIDTH-1:0];
            qts_pkg::CSR_COEF_C2:      coef_ff[2] <= csr_wdata[COEF_WIDTH-1:0];
            qts_pkg::CSR_COEF_C3:      coef_ff[3] <= csr_wdata[COEF_WIDTH-1:0];
            qts_pkg::CSR_COEF_C4:      coef_ff[4] <= csr_wdata[COEF_WIDTH-1:0];
            qts_pkg::CSR_COEF_C5:      coef_ff[5] <= csr_wdata[COEF_WIDTH-1:0];
            qts_pkg::CSR_TIME_STEP:    step_ff    <= csr_wdata[31:0];
            qts_pkg::CSR_SAMPLE_COUNT: count_ff   <= csr_wdata[COUNT_WIDTH-1:0];
            default:                   step_ff    <= step_ff;
         endcase
      end
   end

   // time and sample index
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff  <= '0;
         index_ff <= '0;
      end else if (cmd.accept && restart) begin
         time_ff  <= '0;
         index_ff <= '0;
      end else if (cmd.out_load && !pe_ff) begin
         time_ff  <= time_ff + step_ff;
         index_ff <= index_ff + COUNT_WIDTH'(1);
      end
   end

   // pipeline control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_valid_ff <= 1'b0;
         pe_ff       <= 1'b0;
      end else begin
         wb_valid_ff <= cmd.issue;
         if (cmd.init) begin
            pe_ff <= status.past_end;
         end
      end
   end

   // multiplier and coefficient registers
   always_ff @(posedge clock) begin
      wb_lane_ff <= cmd.lane;
      prod_ff    <= full_prod[63:24];
      k_ff       <= scale_sat(coef_ff[cmd.coef_sel], cmd.scale);
   end

   // accumulators: start from the scaled top coefficient, then horner steps
   always_ff @(posedge clock) begin
      if (cmd.init) begin
         acc_ff[qts_pkg::LANE_POS] <= scale_sat(coef_ff[5], qts_pkg::SCALE_1);
         acc_ff[qts_pkg::LANE_VEL] <= scale_sat(coef_ff[5], qts_pkg::SCALE_5);
         acc_ff[qts_pkg::LANE_ACC] <= scale_sat(coef_ff[5], qts_pkg::SCALE_20);
      end else if (wb_valid_ff) begin
         acc_ff[wb_lane_ff] <= sum_sat;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (pe_ff) begin
            pos_ff       <= '0;
            vel_ff       <= '0;
            accel_ff     <= '0;
            index_out_ff <= '0;
            final_ff     <= 1'b0;
            past_end_ff  <= 1'b1;
         end else begin
            pos_ff       <= acc_ff[qts_pkg::LANE_POS];
            vel_ff       <= acc_ff[qts_pkg::LANE_VEL];
            accel_ff     <= acc_ff[qts_pkg::LANE_ACC];
            index_out_ff <= index_wide[IXW-1:0];
            final_ff     <= is_final;
            past_end_ff  <= 1'b0;
         end
      end
   end

   assign position     = pos_ff;
   assign velocity     = vel_ff;
   assign acceleration = accel_ff;
   assign index_out    = index_out_ff;
   assign final_sample = final_ff;
   assign past_end     = past_end_ff;

endmodule

// ----- src/quintic_trajectory_sampler.sv -----
// quintic_trajectory_sampler: top level joining qts_ctrl and qts_datapath; uses qts_pkg
// Sequence: accept, load (INIT), the horner schedule (RUN), drain and hand-off (DONE);
// a past-end request skips the schedule and goes from load straight to hand-off. One
// request at a time: the horner schedule on the single 32x33 multiplier, plus load, drain and hand-off, sets this.
// Reset: synchronous, active high; clears coefficients, step, count, time,
// index and all control state.
module quintic_trajectory_sampler #(
   parameter int COUNT_WIDTH = 16,
   parameter int COEF_WIDTH  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qts_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [((COEF_WIDTH > 32) ? COEF_WIDTH : 32)-1:0] csr_wdata,
   // sample requests
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // restart[0]
   // samples
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // position[31:0], velocity[63:32], acceleration[95:64], index_out[111:96]
   output logic [111:0]                        rsp_tdata,
   output logic                                rsp_tlast,  // final_sample
   output logic                                rsp_tuser   // past_end
);

   qts_pkg::cmd_type    cmd;
   qts_pkg::status_type status;
   logic signed [31:0]  position, velocity, acceleration;
   logic [qts_pkg::INDEX_WIDTH-1:0] index_out;

   assign csr_ready = 1'b1;

   // sequencer
   qts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic and state
   qts_datapath #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .COEF_WIDTH  (COEF_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .restart      (req_tdata[0]),
      .cmd          (cmd),
      .status       (status),
      .position     (position),
      .velocity     (velocity),
      .acceleration (acceleration),
      .index_out    (index_out),
      .final_sample (rsp_tlast),
      .past_end     (rsp_tuser)
   );

   assign rsp_tdata = {index_out, acceleration, velocity, position};

   // a past-end sample carries zero values and never closes a run
   a_past_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0 && !rsp_tlast))
      else $error("past-end sample with non-zero payload");

   // one request in flight: no second transfer right after an accepted one
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while busy");

   // no result appears directly after an accepted request while none is pending
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result appeared too early");

endmodule

// ----- bench/quintic_trajectory_sampler_test.sv -----
// quintic_trajectory_sampler_test: self-checking bench for the quintic trajectory sampler
// depends on qts_pkg and quintic_trajectory_sampler; predicts every sample in fixed point
// and compares it with the rsp stream, while both sides of the bus idle at random
`timescale 1ns / 100ps

module quintic_trajectory_sampler_test;

   localparam int CLOCK_PERIOD = 10;
   localparam int MAX_GAP      = 4;
   localparam int RANDOM_ITEMS = 1300;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [31:0] ONE_SECOND = 32'h0100_0000;
   localparam logic [31:0] Q16_MAX    = 32'h7FFF_FFFF;
   localparam logic [31:0] Q16_MIN    = 32'h8000_0000;

   localparam longint SAT_HIGH = 64'sd2147483647;
   localparam longint SAT_LOW  = -64'sd2147483648;

   // one predicted sample
   typedef struct {
      logic [31:0]                     position;
      logic [31:0]                     velocity;
      logic [31:0]                     acceleration;
      logic [qts_pkg::INDEX_WIDTH-1:0] index;
      logic                            last_flag;
      logic                            past_end;
   } sample_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [qts_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0]                         csr_wdata = '0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [7:0]                          req_tdata = '0;   // restart[0]
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   // position[31:0], velocity[63:32], acceleration[95:64], index_out[111:96]
   logic [111:0]                        rsp_tdata;
   logic                                rsp_tlast;        // final_sample
   logic                                rsp_tuser;        // past_end

   // trajectory state as the bench sees it
   longint           coef_q [qts_pkg::NUM_COEF];
   logic [31:0]      step_q = '0;
   logic [15:0]      count_q = '0;
   logic [31:0]      traj_time = '0;
   logic [15:0]      traj_index = '0;

   sample_type       expected_samples [$];
   sample_type       want;
   int unsigned      next_hold;
   int unsigned      sample_hold = 0;
   int               failures = 0;
   bit               no_idle = 1'b0;

   quintic_trajectory_sampler dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int unsigned draw_gap();
      return no_idle ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic longint clamp32(longint v);
      if (v > SAT_HIGH) return SAT_HIGH;
      if (v < SAT_LOW) return SAT_LOW;
      return v;
   endfunction

   // horner over the first n terms, highest order first, q8.24 time
   function automatic longint horner_eval(longint k [qts_pkg::NUM_COEF], int n,
                                          logic [31:0] t);
      longint acc;
      longint prod;
      acc = k[0];
      for (int i = 1; i < n; i++) begin
         prod = acc * longint'(t);
         acc = clamp32((prod >>> 24) + k[i]);
      end
      return acc;
   endfunction

   // next sample of the trajectory, advancing time and index
   function automatic sample_type sample_trajectory(bit restart);
      sample_type s;
      longint  kp [qts_pkg::NUM_COEF];
      longint  kv [qts_pkg::NUM_COEF];
      longint  ka [qts_pkg::NUM_COEF];
      longint  pos;
      longint  vel;
      longint  acc;
      s = '{default: '0};
      if (restart) begin
         traj_time  = '0;
         traj_index = '0;
      end
      if (traj_index >= count_q) begin
         s.past_end = 1'b1;
         return s;
      end
      kp = '{default: 0};
      kv = '{default: 0};
      ka = '{default: 0};
      for (int i = 0; i < qts_pkg::NUM_COEF; i++) begin
         kp[i] = clamp32(coef_q[qts_pkg::NUM_COEF - 1 - i]);
      end
      kv[0] = clamp32(5 * coef_q[5]);
      kv[1] = clamp32(4 * coef_q[4]);
      kv[2] = clamp32(3 * coef_q[3]);
      kv[3] = clamp32(2 * coef_q[2]);
      kv[4] = clamp32(coef_q[1]);
      ka[0] = clamp32(20 * coef_q[5]);
      ka[1] = clamp32(12 * coef_q[4]);
      ka[2] = clamp32(6 * coef_q[3]);
      ka[3] = clamp32(2 * coef_q[2]);
      pos = horner_eval(kp, 6, traj_time);
      vel = horner_eval(kv, 5, traj_time);
      acc = horner_eval(ka, 4, traj_time);
      s.position     = pos[31:0];
      s.velocity     = vel[31:0];
      s.acceleration = acc[31:0];
      s.index        = traj_index;
      s.last_flag    = (32'(traj_index) + 1 == 32'(count_q));
      traj_time  = traj_time + step_q;
      traj_index = traj_index + 16'd1;
      return s;
   endfunction

   // one register transfer on the csr channel
   task automatic write_register(logic [qts_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         qts_pkg::CSR_TIME_STEP:    step_q = value;
         qts_pkg::CSR_SAMPLE_COUNT: count_q = value[15:0];
         default:                   coef_q[index] = longint'($signed(value));
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_trajectory(logic [31:0] c [qts_pkg::NUM_COEF], logic [31:0] step,
                                  logic [15:0] count);
      for (int i = 0; i < qts_pkg::NUM_COEF; i++) begin
         write_register(qts_pkg::CSR_COEF_C0 + i[2:0], c[i]);
      end
      write_register(qts_pkg::CSR_TIME_STEP, step);
      write_register(qts_pkg::CSR_SAMPLE_COUNT, {16'd0, count});
   endtask

   // one tick transfer; valid stays high when the next tick follows at once
   task automatic send_tick(bit restart);
      int unsigned gap;
      sample_type  s;
      gap = draw_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, restart};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      s = sample_trajectory(restart);
      expected_samples.insert(expected_samples.size(), s);
   endtask

   // stop ticking and wait for every outstanding sample
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
   endtask

   // count of zero straight after reset: every tick is past end
   task automatic test_idle_after_reset();
      send_tick(1'b0);
      send_tick(1'b1);
      settle();
   endtask

   // all coefficients at the limits, so the horner sums clip once time has advanced
   task automatic test_saturation();
      logic [31:0] c [qts_pkg::NUM_COEF];
      c = '{default: Q16_MAX};
      load_trajectory(c, ONE_SECOND, 16'd2);
      send_tick(1'b1);
      send_tick(1'b0);
      settle();
      c = '{default: Q16_MIN};
      load_trajectory(c, ONE_SECOND, 16'd2);
      send_tick(1'b1);
      send_tick(1'b0);
      settle();
   endtask

   // restart at the start, after the end and in the middle of a run
   task automatic test_restart();
      logic [31:0] c [qts_pkg::NUM_COEF];
      c = '{32'h0001_0000, 32'hFFFF_8000, 32'h0000_4000, 32'hFFFF_F000,
            32'h0000_0800, 32'h0000_0100};
      load_trajectory(c, 32'h0040_0000, 16'd3);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      settle();
   endtask

   // largest step, time wraps round after the second sample
   task automatic test_time_wrap();
      logic [31:0] c [qts_pkg::NUM_COEF];
      c = '{32'h0000_1000, 32'h0000_0200, 32'hFFFF_FF00, 32'h0000_0010,
            32'hFFFF_FFF8, 32'h0000_0001};
      load_trajectory(c, 32'hFFFF_FFFF, 16'hFFFF);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      settle();
   endtask

   // count lowered below the index mid run, then raised again
   task automatic test_count_lowered();
      logic [31:0] c [qts_pkg::NUM_COEF];
      c = '{32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
            32'h0000_2000, 32'hFFFF_F800};
      load_trajectory(c, 32'h0080_0000, 16'd6);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      settle();
      write_register(qts_pkg::CSR_SAMPLE_COUNT, 32'd2);
      send_tick(1'b0);
      settle();
      write_register(qts_pkg::CSR_SAMPLE_COUNT, 32'd5);
      send_tick(1'b0);
      send_tick(1'b0);
      settle();
   endtask

   function automatic logic [31:0] draw_coef(int unsigned mode);
      logic [31:0] v;
      case (mode)
         0: v = $urandom();
         1: v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
         default: begin
            v = $urandom() >> $urandom_range(0, 31);
            if ($urandom_range(0, 1) != 0) v = -v;
         end
      endcase
      return v;
   endfunction

   // random trajectories, mostly runs from a restart with the odd stray restart
   task automatic test_random_runs();
      logic [31:0] c [qts_pkg::NUM_COEF];
      logic [31:0] step;
      logic [15:0] count;
      int unsigned mode;
      int unsigned pick;
      int          run_len;
      int          sent;
      bit          noisy;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         noisy   = ($urandom_range(0, 4) == 0);
         mode    = $urandom_range(0, 2);
         for (int i = 0; i < qts_pkg::NUM_COEF; i++) c[i] = draw_coef(mode);
         case (mode)
            0: step = $urandom();
            1: step = $urandom_range(1, 32'h0040_0000);
            default: step = $urandom() >> $urandom_range(0, 31);
         endcase
         pick = $urandom_range(0, 9);
         if (pick == 0) count = '0;
         else if (pick == 1) count = 16'($urandom_range(0, 16'hFFFF));
         else count = 16'($urandom_range(1, 40));
         load_trajectory(c, step, count);
         run_len = $urandom_range(8, 60);
         send_tick($urandom_range(0, 3) != 0);
         for (int i = 1; i < run_len; i++) begin
            if (noisy) send_tick($urandom_range(0, 1) != 0);
            else send_tick($urandom_range(0, 19) == 0);
         end
         sent += run_len;
         settle();
      end
      no_idle = 1'b0;
   endtask

   // result side: random hold-off per transfer, compare with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         sample_hold <= draw_gap();
      end else if (rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            $error("unexpected sample transfer: data %h", rsp_tdata);
            failures++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_tdata[31:0] !== want.position) begin
               $error("position: expected %h, got %h", want.position, rsp_tdata[31:0]);
               failures++;
            end
            if (rsp_tdata[63:32] !== want.velocity) begin
               $error("velocity: expected %h, got %h", want.velocity, rsp_tdata[63:32]);
               failures++;
            end
            if (rsp_tdata[95:64] !== want.acceleration) begin
               $error("acceleration: expected %h, got %h", want.acceleration,
                      rsp_tdata[95:64]);
               failures++;
            end
            if (rsp_tdata[111:96] !== want.index) begin
               $error("index_out: expected %0d, got %0d", want.index, rsp_tdata[111:96]);
               failures++;
            end
            if (rsp_tlast !== want.last_flag) begin
               $error("final_sample: expected %b, got %b", want.last_flag, rsp_tlast);
               failures++;
            end
            if (rsp_tuser !== want.past_end) begin
               $error("past_end: expected %b, got %b", want.past_end, rsp_tuser);
               failures++;
            end
         end
         next_hold = draw_gap();
         sample_hold <= next_hold;
         rsp_tready  <= (next_hold == 0);
      end else if (sample_hold != 0) begin
         sample_hold <= sample_hold - 1;
         rsp_tready  <= (sample_hold == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // test sequence
   initial begin
      for (int i = 0; i < qts_pkg::NUM_COEF; i++) coef_q[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_after_reset();
      test_saturation();
      test_restart();
      test_time_wrap();
      test_count_lowered();
      test_random_runs();
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_samples.size() == 0) begin
         $display("** quintic_trajectory_sampler: PASSED **");
      end else begin
         $display("** quintic_trajectory_sampler: FAILED **");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("** quintic_trajectory_sampler: FAILED **");
      $finish;
   end

endmodule
